/* hdl/fsmd_pkg.sv */
// ----------------------------------------------------------------------------
// fsmd_pkg: shared types and constants
// Types and fixed widths for the facility subset minimum distance block.
// ----------------------------------------------------------------------------
package fsmd_pkg;

	localparam int COORD_W = 6;
	localparam int DIST_W  = 7;
	localparam int TOTAL_W = 14;
	localparam int SIDE_W  = 7;
	localparam int KEEP_W  = 5;
	localparam int KIND_W  = 2;

	localparam logic [KIND_W-1:0] KIND_DEMAND = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SITE   = 2'd2;

	localparam logic REG_GRID_SIDE  = 1'b0;
	localparam logic REG_KEEP_COUNT = 1'b1;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = 14'h3FFF;
	localparam logic [DIST_W-1:0]  DIST_MAX  = 7'h7F;

	typedef struct packed {
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} point_t;

endpackage

/* hdl/fsmd_subset_gen.sv */
// ----------------------------------------------------------------------------
// fsmd_subset_gen: next subset of equal population
// Steps a site mask to the next larger mask with the same number of ones.
// ----------------------------------------------------------------------------
module fsmd_subset_gen #(
	parameter int SITES = 16
) (
	input  logic [SITES-1:0] mask,
	output logic [SITES:0]   next_mask
);
	logic [SITES:0] m;
	logic [SITES:0] low;
	logic [SITES:0] r;
	logic [SITES:0] ones;
	logic [SITES:0] sh;
	int unsigned    lz;

	// lowest set bit, ripple sum, then right-justify the changed ones
	always_comb begin
		m    = {1'b0, mask};
		low  = m & (~m + 1'b1);
		r    = m + low;
		ones = (r ^ m) >> 2;
		lz   = 0;
		for (int i = SITES; i >= 0; i--) begin
			if (low[i]) lz = i;
		end
		sh        = ones >> lz;
		next_mask = sh | r;
	end
endmodule

/* hdl/facility_subset_min_distance.sv */
// ----------------------------------------------------------------------------
// facility_subset_min_distance: exhaustive p-median search, Manhattan metric
// Loads a grid cell by cell, then tries every keep_count-subset of facilities.
// ----------------------------------------------------------------------------
//  channel | direction | signals
//  --------+-----------+---------------------------------------------------
//  cell    | in        | cell_valid, cell_ready, cell_kind
//  result  | out       | result_valid, result_ready, total_distance,
//          |           | no_selection, overflow
//  config  | in        | cfg_we, cfg_index, cfg_data
//
// Cells transfer one per cycle while loading. After the last cell a distance
// pass writes demand x site distances into the pair memory, and reads wait
// for the last write to land before the first read; then every subset is
// scored by reading that memory, one entry per cycle, a pace set by the
// single read port.
// The result sits in an output register; no cell is taken until it transfers.
// Reset clears counts, scan position and control; memories need no clearing.
module facility_subset_min_distance #(
	parameter int MAX_DEMAND = 128,
	parameter int MAX_SITES  = 16,
	parameter int MAX_SIDE   = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cell_valid,
	output logic                            cell_ready,
	input  logic [fsmd_pkg::KIND_W-1:0]     cell_kind,
	output logic                            result_valid,
	input  logic                            result_ready,
	output logic [fsmd_pkg::TOTAL_W-1:0]    total_distance,
	output logic                            no_selection,
	output logic                            overflow,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [fsmd_pkg::SIDE_W-1:0]     cfg_data
);
	localparam int DW = (MAX_DEMAND > 1) ? $clog2(MAX_DEMAND) : 1;
	localparam int SW = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
	localparam int DCW = $clog2(MAX_DEMAND + 1);
	localparam int SCW = $clog2(MAX_SITES + 1);
	localparam int PW = DW + SW;
	localparam int SUMW = DCW + fsmd_pkg::DIST_W;

	localparam logic [2:0] ST_LOAD = 3'd0;
	localparam logic [2:0] ST_DIST = 3'd1;
	localparam logic [2:0] ST_EVAL = 3'd2;
	localparam logic [2:0] ST_NEXT = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0] state_q;
	logic [fsmd_pkg::SIDE_W-1:0] side_q;
	logic [fsmd_pkg::KEEP_W-1:0] keep_q;
	logic [fsmd_pkg::COORD_W-1:0] col_q, row_q;
	logic [DCW-1:0] dcnt_q;
	logic [SCW-1:0] scnt_q;
	logic ovf_q;

	// point stores and pair distance memory (site index in the low bits)
	fsmd_pkg::point_t dmem [MAX_DEMAND];
	fsmd_pkg::point_t smem [MAX_SITES];
	logic [fsmd_pkg::DIST_W-1:0] pmem [MAX_DEMAND*(2**SW)];

	logic [DW-1:0] di_q;
	logic [SW-1:0] si_q;
	logic [MAX_SITES-1:0] mask_q;
	logic [SUMW-1:0] total_q;
	logic [SUMW-1:0] best_q;
	logic [fsmd_pkg::DIST_W-1:0] near_q;
	logic rd_vld_s1, rd_last_s1, rd_dlast_s1, rd_sel_s1;
	logic [fsmd_pkg::DIST_W-1:0] rd_data_s1;
	fsmd_pkg::point_t dp_s1, sp_s1;
	logic dist_vld_s1;
	logic [PW-1:0] dist_addr_s1;
	logic [MAX_SITES:0] next_mask;

	logic [fsmd_pkg::COORD_W-1:0] side_m1;
	logic last_col, last_row, take;
	logic [fsmd_pkg::COORD_W-1:0] dc, dr;
	logic [fsmd_pkg::DIST_W-1:0] dist_val;
	logic [fsmd_pkg::DIST_W-1:0] near_new;
	logic [SUMW-1:0] total_new;
	logic di_last, si_last;
	logic feasible, dist_go, rd_go;

	always_comb begin
		if (side_q == '0) side_m1 = '0;
		else if (side_q > fsmd_pkg::SIDE_W'(MAX_SIDE))
			side_m1 = fsmd_pkg::COORD_W'(MAX_SIDE - 1);
		else side_m1 = fsmd_pkg::COORD_W'(side_q - 1'b1);
	end
	assign last_col = col_q >= side_m1;
	assign last_row = row_q >= side_m1;
	assign cell_ready = (state_q == ST_LOAD);
	assign take = cell_valid && cell_ready;
	assign di_last = (DCW'(di_q) == DCW'(dcnt_q - 1'b1)) || (dcnt_q == '0);
	assign si_last = (SCW'(si_q) == SCW'(scnt_q - 1'b1));

	// keep 0 or more than the stored sites: no subset exists
	assign feasible = !(keep_q == '0 || int'(keep_q) > int'(scnt_q));
	assign dist_go = (state_q == ST_DIST) && feasible && (dcnt_q != '0);
	// hold reads while the last distance write or a subset's last read is still landing
	assign rd_go = (state_q == ST_EVAL) && !dist_vld_s1 && !(rd_vld_s1 && rd_dlast_s1);

	fsmd_subset_gen #(.SITES(MAX_SITES)) u_gen (.mask(mask_q), .next_mask(next_mask));

	// Manhattan distance of the registered pair
	assign dc = (dp_s1.col > sp_s1.col) ? dp_s1.col - sp_s1.col : sp_s1.col - dp_s1.col;
	assign dr = (dp_s1.row > sp_s1.row) ? dp_s1.row - sp_s1.row : sp_s1.row - dp_s1.row;
	assign dist_val = {1'b0, dc} + {1'b0, dr};

	assign near_new = (rd_sel_s1 && rd_data_s1 < near_q) ? rd_data_s1 : near_q;
	assign total_new = total_q + SUMW'(near_new);

	// memories: store writes, distance pass writes, registered reads
	always_ff @(posedge clk) begin
		if (take && cell_kind == fsmd_pkg::KIND_DEMAND && dcnt_q < DCW'(MAX_DEMAND))
			dmem[dcnt_q[DW-1:0]] <= '{col: col_q, row: row_q};
		if (take && cell_kind == fsmd_pkg::KIND_SITE && scnt_q < SCW'(MAX_SITES))
			smem[scnt_q[SW-1:0]] <= '{col: col_q, row: row_q};
		dp_s1 <= dmem[di_q];
		sp_s1 <= smem[si_q];
		dist_addr_s1 <= {di_q, si_q};
		if (dist_vld_s1) pmem[dist_addr_s1] <= dist_val;
		rd_data_s1 <= pmem[{di_q, si_q}];
		rd_sel_s1 <= mask_q[si_q];
		rd_last_s1 <= si_last;
		rd_dlast_s1 <= si_last && di_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			side_q <= 7'd1;
			keep_q <= 5'd1;
			col_q <= '0;
			row_q <= '0;
			dcnt_q <= '0;
			scnt_q <= '0;
			ovf_q <= 1'b0;
			di_q <= '0;
			si_q <= '0;
			mask_q <= '0;
			total_q <= '0;
			best_q <= '0;
			near_q <= '0;
			rd_vld_s1 <= 1'b0;
			dist_vld_s1 <= 1'b0;
			result_valid <= 1'b0;
			total_distance <= '0;
			no_selection <= 1'b0;
			overflow <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == fsmd_pkg::REG_GRID_SIDE) side_q <= cfg_data;
				else keep_q <= cfg_data[fsmd_pkg::KEEP_W-1:0];
			end
			dist_vld_s1 <= dist_go;
			rd_vld_s1 <= rd_go;
			unique case (state_q)
				ST_LOAD: begin
					if (take) begin
						if (cell_kind == fsmd_pkg::KIND_DEMAND) begin
							if (dcnt_q < DCW'(MAX_DEMAND)) dcnt_q <= dcnt_q + 1'b1;
							else ovf_q <= 1'b1;
						end else if (cell_kind == fsmd_pkg::KIND_SITE) begin
							if (scnt_q < SCW'(MAX_SITES)) scnt_q <= scnt_q + 1'b1;
							else ovf_q <= 1'b1;
						end
						if (last_col && last_row) begin
							di_q <= '0;
							si_q <= '0;
							state_q <= ST_DIST;
						end else if (last_col) begin
							col_q <= '0;
							row_q <= row_q + 1'b1;
						end else begin
							col_q <= col_q + 1'b1;
						end
					end
				end
				ST_DIST: begin
					// counts final here; check feasibility first
					if (!feasible) begin
						total_distance <= '0;
						no_selection <= 1'b1;
						overflow <= ovf_q;
						result_valid <= 1'b1;
						state_q <= ST_OUT;
					end else if (dcnt_q == '0) begin
						total_distance <= '0;
						no_selection <= 1'b0;
						overflow <= ovf_q;
						result_valid <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						if (si_last) begin
							si_q <= '0;
							if (di_last) begin
								di_q <= '0;
								mask_q <= MAX_SITES'((32'd1 << keep_q) - 1);
								best_q <= '1;
								total_q <= '0;
								near_q <= fsmd_pkg::DIST_MAX;
								state_q <= ST_EVAL;
							end else di_q <= di_q + 1'b1;
						end else si_q <= si_q + 1'b1;
					end
				end
				ST_EVAL: begin
					// one read per cycle unless reads are held, fold the previous read
					if (rd_vld_s1) begin
						if (rd_last_s1) begin
							total_q <= total_new;
							near_q <= fsmd_pkg::DIST_MAX;
						end else near_q <= near_new;
					end
					if (rd_go) begin
						if (si_last) begin
							si_q <= '0;
							if (!di_last) di_q <= di_q + 1'b1;
						end else si_q <= si_q + 1'b1;
					end else if (rd_vld_s1 && rd_dlast_s1) begin
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					if (total_q < best_q) best_q <= total_q;
					total_q <= '0;
					di_q <= '0;
					si_q <= '0;
					if ((next_mask >> scnt_q) != '0) begin
						total_distance <= (((total_q < best_q) ? total_q : best_q)
							> SUMW'(fsmd_pkg::TOTAL_MAX)) ? fsmd_pkg::TOTAL_MAX :
							fsmd_pkg::TOTAL_W'((total_q < best_q) ? total_q : best_q);
						no_selection <= 1'b0;
						overflow <= ovf_q;
						result_valid <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						mask_q <= next_mask[MAX_SITES-1:0];
						state_q <= ST_EVAL;
					end
				end
				ST_OUT: begin
					if (result_ready) begin
						result_valid <= 1'b0;
						col_q <= '0;
						row_q <= '0;
						dcnt_q <= '0;
						scnt_q <= '0;
						ovf_q <= 1'b0;
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end
endmodule

/* hdl/fsmd_checker.sv */
// ----------------------------------------------------------------------------
// fsmd_checker: port-level checks
// Watches the top level's channels over time.
// ----------------------------------------------------------------------------
module fsmd_checker (
	input logic clk,
	input logic arst_n,
	input logic cell_ready,
	input logic result_valid,
	input logic result_ready,
	input logic [fsmd_pkg::TOTAL_W-1:0] total_distance,
	input logic no_selection
);
	// a pending result blocks cells
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !cell_ready) else $error("cell taken with result pending");

	// result holds until transferred
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(total_distance))
		else $error("result dropped");

	// no selection reports zero total
	a_nosel: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && no_selection |-> total_distance == '0)
		else $error("nonzero total with no selection");

	// after a result transfer the block loads again
	a_back: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready |=> cell_ready && !result_valid)
		else $error("not back to loading");
endmodule

bind facility_subset_min_distance fsmd_checker u_chk (
	.clk(clk), .arst_n(arst_n), .cell_ready(cell_ready),
	.result_valid(result_valid), .result_ready(result_ready),
	.total_distance(total_distance), .no_selection(no_selection)
);
